// ===== src/one_bpp_bit_aligned_blit_core_macros.svh =====
// assertion macros for the 1bpp blit core
`ifndef ONE_BPP_BIT_ALIGNED_BLIT_CORE_MACROS_SVH
`define ONE_BPP_BIT_ALIGNED_BLIT_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define BLT_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define BLT_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) cond |=> prop) else $error("%m failed");
`else
`define BLT_ASSERT(label, clk, rst_n, prop)
`define BLT_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

// ===== src/blt_pkg.sv =====
// shared types and constants of the 1bpp blit core
`timescale 1ns / 1ps
package blt_pkg;
  localparam int SrcWordsPerRow = 20;
  localparam int SrcRows = 480;
  localparam int DstWordsPerRow = 20;
  localparam int DstRows = 480;
  localparam int AddrW = 14;
  localparam int WordW = 32;

  typedef enum logic [2:0] {
    FN_WR_SRC = 3'd0,
    FN_RD_SRC = 3'd1,
    FN_WR_DST = 3'd2,
    FN_RD_DST = 3'd3,
    FN_BLIT   = 3'd4
  } func_e;

  // one classified command handed from front to back
  typedef struct packed {
    logic [2:0]  func;
    logic        in_range;
    logic [13:0] addr;
    logic [31:0] data;
    logic [9:0]  src_x;
    logic [8:0]  src_y;
    logic [9:0]  dst_x;
    logic [8:0]  dst_y;
    logic [9:0]  width;
    logic [8:0]  height;
    logic        empty;
  } cmd_t;
endpackage

// ===== src/blt_ram.sv =====
// generic single port ram with registered read
`timescale 1ns / 1ps
module blt_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ===== src/blt_front.sv =====
// front: accepts commands, classifies them, pushes into a two entry queue
`timescale 1ns / 1ps
module blt_front import blt_pkg::*; #(
  parameter int SrcDepth = SrcWordsPerRow * SrcRows,
  parameter int DstDepth = DstWordsPerRow * DstRows
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic [2:0]  func_i,
  input  logic [13:0] addr_i,
  input  logic [31:0] data_i,
  input  logic [9:0]  src_x_i,
  input  logic [8:0]  src_y_i,
  input  logic [9:0]  dst_x_i,
  input  logic [8:0]  dst_y_i,
  input  logic [9:0]  width_i,
  input  logic [8:0]  height_i,
  output logic        full_o,
  output logic        valid_o,
  output cmd_t        cmd_o,
  input  logic        pop_i
);
  cmd_t cmd_d;
  cmd_t fifo_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  always_comb begin
    cmd_d = '0;
    cmd_d.func = func_i;
    cmd_d.addr = addr_i;
    cmd_d.data = data_i;
    cmd_d.src_x = src_x_i;
    cmd_d.src_y = src_y_i;
    cmd_d.dst_x = dst_x_i;
    cmd_d.dst_y = dst_y_i;
    cmd_d.width = width_i;
    cmd_d.height = height_i;
    cmd_d.empty = (width_i == '0) || (height_i == '0);
    unique case (func_i) inside
      FN_WR_SRC, FN_RD_SRC: cmd_d.in_range = (32'(addr_i) < 32'(SrcDepth));
      FN_WR_DST, FN_RD_DST: cmd_d.in_range = (32'(addr_i) < 32'(DstDepth));
      default:              cmd_d.in_range = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      fifo_q[wp_q] <= cmd_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= ~wp_q;
      end
      if (pop_i) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  assign full_o  = cnt_q[1];
  assign valid_o = cnt_q != '0;
  assign cmd_o   = fifo_q[rp_q];
endmodule

// ===== src/blt_back.sv =====
// back: carries out store accesses and walks blits word by word
`timescale 1ns / 1ps
module blt_back import blt_pkg::*; #(
  parameter int SrcWpr = SrcWordsPerRow,
  parameter int SrcRowsP = SrcRows,
  parameter int DstWpr = DstWordsPerRow,
  parameter int DstRowsP = DstRows
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  cmd_t        cmd_i,
  output logic        pop_o,
  output logic        idle_o,
  output logic        done_o,
  output logic [31:0] read_data_o,
  output logic [2:0]  done_kind_o
);
  localparam int SrcDepth = SrcWpr * SrcRowsP;
  localparam int DstDepth = DstWpr * DstRowsP;
  localparam int SAW = $clog2(SrcDepth);
  localparam int DAW = $clog2(DstDepth);

  typedef enum logic [2:0] {
    ST_IDLE, ST_ACC, ST_WAIT, ST_ROW, ST_RD, ST_LO, ST_HI, ST_WR
  } state_e;

  state_e      state_q;
  cmd_t        cmd_q;
  logic [8:0]  j_q;
  logic [5:0]  wi_q, w1_q;
  logic [31:0] lo_q, old_q;
  logic [11:0] srow_q, drow_q;
  logic        lo_ok_q;

  logic             s_we, d_we;
  logic [SAW-1:0]   s_addr;
  logic [DAW-1:0]   d_addr;
  logic [31:0]      s_wdata, d_wdata, s_rdata, d_rdata;

  blt_ram #(.Width(32), .Depth(SrcDepth)) u_src (
    .clk_i, .we_i(s_we), .addr_i(s_addr), .wdata_i(s_wdata), .rdata_o(s_rdata));
  blt_ram #(.Width(32), .Depth(DstDepth)) u_dst (
    .clk_i, .we_i(d_we), .addr_i(d_addr), .wdata_i(d_wdata), .rdata_o(d_rdata));

  // per word geometry
  logic [10:0] dx1, first;
  logic signed [12:0] sx0;
  logic signed [8:0]  swd;
  logic [4:0]  sh;
  logic        lo_ok, hi_ok, row_ok;
  logic [31:0] val, mask, lmask, rmask;
  logic [23:0] s_base, d_base;

  always_comb begin
    dx1   = 11'(cmd_q.dst_x) + 11'(cmd_q.width);
    first = {wi_q, 5'd0};
    sx0   = 13'(cmd_q.src_x) + $signed({2'b0, first}) - 13'(cmd_q.dst_x);
    swd   = 9'(sx0 >>> 5);
    sh    = sx0[4:0];
    row_ok = 32'(srow_q) < 32'(SrcRowsP);
    lo_ok = row_ok && !swd[8] && (32'(swd) < 32'(SrcWpr));
    hi_ok = row_ok && ((swd + 9'sd1) >= 0) && (32'(swd + 9'sd1) < 32'(SrcWpr));
    s_base = 24'(srow_q) * 24'(SrcWpr);
    d_base = 24'(drow_q) * 24'(DstWpr);
    lmask = (11'(cmd_q.dst_x) > first) ? (32'hFFFF_FFFF << 5'(cmd_q.dst_x)) : '1;
    rmask = (12'(dx1) < 12'(first) + 12'd32) ? (32'hFFFF_FFFF >> 5'(11'd32 - (dx1 - first)))
                                              : '1;
    mask = lmask & rmask;
    val = (sh == '0) ? lo_q
                     : ((lo_q >> sh) | ((hi_ok ? s_rdata : '0) << (6'd32 - 6'(sh))));
  end

  always_comb begin
    s_we = 1'b0; d_we = 1'b0;
    s_addr = SAW'(cmd_q.addr); d_addr = DAW'(cmd_q.addr);
    s_wdata = cmd_q.data; d_wdata = cmd_q.data;
    unique case (state_q)
      ST_ACC: begin
        s_we = (cmd_q.func == FN_WR_SRC) && cmd_q.in_range;
        d_we = (cmd_q.func == FN_WR_DST) && cmd_q.in_range;
      end
      ST_RD: begin
        s_addr = SAW'(s_base + 24'(swd));
        d_addr = DAW'(d_base + 24'(wi_q));
      end
      ST_LO: s_addr = SAW'(s_base + 24'(swd) + 24'd1);
      // keep the high word on the read port until the write step
      ST_HI: s_addr = SAW'(s_base + 24'(swd) + 24'd1);
      ST_WR: begin
        d_addr = DAW'(d_base + 24'(wi_q));
        d_wdata = (old_q & ~mask) | (val & mask);
        d_we = 32'(wi_q) < 32'(DstWpr);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && state_q == ST_IDLE) cmd_q <= cmd_i;
    if (state_q == ST_LO) begin
      lo_q <= lo_ok_q ? s_rdata : '0;
      old_q <= d_rdata;
    end
    if (state_q == ST_RD) lo_ok_q <= lo_ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_o <= 1'b0;
      read_data_o <= '0;
      done_kind_o <= '0;
      j_q <= '0; wi_q <= '0; w1_q <= '0; srow_q <= '0; drow_q <= '0;
    end else begin
      done_o <= 1'b0;
      unique case (state_q)
        ST_IDLE: if (valid_i) begin
          state_q <= (cmd_i.func == FN_BLIT && !cmd_i.empty) ? ST_ROW : ST_ACC;
          j_q <= '0;
          srow_q <= 12'(cmd_i.src_y);
          drow_q <= 12'(cmd_i.dst_y);
          w1_q <= 6'((11'(cmd_i.dst_x) + 11'(cmd_i.width) - 11'd1) >> 5);
        end
        ST_ACC: begin
          state_q <= (cmd_q.func == FN_RD_SRC || cmd_q.func == FN_RD_DST) ? ST_WAIT
                                                                           : ST_IDLE;
          if (!(cmd_q.func == FN_RD_SRC || cmd_q.func == FN_RD_DST)) begin
            done_o <= 1'b1;
            read_data_o <= '0;
            done_kind_o <= cmd_q.func;
          end
        end
        ST_WAIT: begin
          state_q <= ST_IDLE;
          done_o <= 1'b1;
          done_kind_o <= cmd_q.func;
          read_data_o <= !cmd_q.in_range ? '0 :
                         (cmd_q.func == FN_RD_SRC) ? s_rdata : d_rdata;
        end
        ST_ROW: begin
          wi_q <= 6'(cmd_q.dst_x >> 5);
          if (32'(drow_q) < 32'(DstRowsP)) state_q <= ST_RD;
          else if (j_q + 9'd1 == cmd_q.height) begin
            state_q <= ST_IDLE; done_o <= 1'b1;
            read_data_o <= '0; done_kind_o <= FN_BLIT;
          end else begin
            j_q <= j_q + 9'd1; srow_q <= srow_q + 12'd1; drow_q <= drow_q + 12'd1;
          end
        end
        ST_RD: state_q <= ST_LO;
        ST_LO: state_q <= ST_HI;
        ST_HI: state_q <= ST_WR;
        ST_WR: begin
          if (wi_q != w1_q) begin
            wi_q <= wi_q + 6'd1; state_q <= ST_RD;
          end else if (j_q + 9'd1 == cmd_q.height) begin
            state_q <= ST_IDLE; done_o <= 1'b1;
            read_data_o <= '0; done_kind_o <= FN_BLIT;
          end else begin
            state_q <= ST_ROW;
            j_q <= j_q + 9'd1; srow_q <= srow_q + 12'd1; drow_q <= drow_q + 12'd1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign pop_o  = valid_i && state_q == ST_IDLE;
  assign idle_o = state_q == ST_IDLE;
endmodule

// ===== src/one_bpp_bit_aligned_blit_core.sv =====
// top level of the 1bpp bit aligned blit core
`timescale 1ns / 1ps
// Commands enter on start while busy is low and land in a two entry queue;
// the back end handles one at a time and pulses done_o with read_data_o and
// done_kind_o for exactly one cycle, which the receiver cannot stall. Reads
// pass through an extra wait state for the registered ram read. A blit walks
// each row destination word by destination word, the back end doing four
// steps per word on the single ram port of each store.
module one_bpp_bit_aligned_blit_core import blt_pkg::*; #(
  parameter int SrcWpr   = SrcWordsPerRow,
  parameter int SrcRowsP = SrcRows,
  parameter int DstWpr   = DstWordsPerRow,
  parameter int DstRowsP = DstRows
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  func_i,
  input  logic [13:0] addr_i,
  input  logic [31:0] data_i,
  input  logic [9:0]  src_x_i,
  input  logic [8:0]  src_y_i,
  input  logic [9:0]  dst_x_i,
  input  logic [8:0]  dst_y_i,
  input  logic [9:0]  width_i,
  input  logic [8:0]  height_i,
  output logic        done_o,
  output logic [31:0] read_data_o,
  output logic [2:0]  done_kind_o
);
`include "one_bpp_bit_aligned_blit_core_macros.svh"
  logic full, valid, pop, idle;
  cmd_t cmd;

  blt_front #(.SrcDepth(SrcWpr * SrcRowsP), .DstDepth(DstWpr * DstRowsP)) u_front (
    .clk_i, .rst_ni, .push_i(start && !busy), .func_i, .addr_i, .data_i,
    .src_x_i, .src_y_i, .dst_x_i, .dst_y_i, .width_i, .height_i,
    .full_o(full), .valid_o(valid), .cmd_o(cmd), .pop_i(pop));

  blt_back #(.SrcWpr(SrcWpr), .SrcRowsP(SrcRowsP), .DstWpr(DstWpr),
             .DstRowsP(DstRowsP)) u_back (
    .clk_i, .rst_ni, .valid_i(valid), .cmd_i(cmd), .pop_o(pop), .idle_o(idle),
    .done_o, .read_data_o, .done_kind_o);

  assign busy = full;

  `BLT_ASSERT(a_pop_idle, clk_i, rst_ni, pop |-> idle)
  `BLT_ASSERT_NEXT(a_pop_leaves, clk_i, rst_ni, pop, !idle)
  `BLT_ASSERT(a_done_data, clk_i, rst_ni,
              (done_o && done_kind_o != FN_RD_SRC && done_kind_o != FN_RD_DST)
              |-> read_data_o == '0)
endmodule
